// ===== rtl/core/pfcd_pkg.sv =====
`default_nettype none

package pfcd_pkg;

  // Pixel format register codes.
  localparam logic FMT_RGB565 = 1'b0;
  localparam logic FMT_RGB888 = 1'b1;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // One raw pixel as it arrives on the input channel.
  typedef struct packed {
    logic [7:0] byte_third;
    logic [7:0] byte_second;
    logic [7:0] byte_first;
    logic       frame_last;
  } raw_pixel_t;

  // Status handed from the CRC unit to the result stage.
  typedef struct packed {
    logic frame_changed;
  } crc_status_t;

  // Reflected CRC-32 over one byte, LSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pfcd_color.sv =====
`default_nettype none

module pfcd_color (
  input  wire logic                  fmt,
  input  wire pfcd_pkg::raw_pixel_t  pix,
  output logic [23:0]                pixel_color
);

  logic [15:0] word565;
  logic [4:0]  red5;
  logic [5:0]  grn6;
  logic [4:0]  blu5;
  logic [7:0]  red8;
  logic [7:0]  grn8;
  logic [7:0]  blu8;

  // floor(v*255/31) = 8*v + floor(7*v/31); the fraction term counts thresholds.
  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [7:0] v7;
    logic [2:0] q;
    v7 = 8'({3'd0, v} * 8'd7);
    q  = '0;
    for (int k = 1; k <= 7; k++) begin
      if (v7 >= 8'(31 * k)) begin
        q = q + 3'd1;
      end
    end
    return {v, 3'b000} + {5'd0, q};
  endfunction

  // floor(v*255/63) = 4*v + floor(v/21).
  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [1:0] q;
    if (v >= 6'd63) begin
      q = 2'd3;
    end else if (v >= 6'd42) begin
      q = 2'd2;
    end else if (v >= 6'd21) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    return {v, 2'b00} + {6'd0, q};
  endfunction

  always_comb begin
    word565 = {pix.byte_second, pix.byte_first};
    red5    = word565[15:11];
    grn6    = word565[10:5];
    blu5    = word565[4:0];
    red8    = widen5(red5);
    grn8    = widen6(grn6);
    blu8    = widen5(blu5);
    if (fmt == pfcd_pkg::FMT_RGB565) begin
      pixel_color = {red8, grn8, blu8};
    end else begin
      pixel_color = {pix.byte_first, pix.byte_second, pix.byte_third};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pfcd_crc.sv =====
`default_nettype none

module pfcd_crc (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  update,
  input  wire logic                  fmt,
  input  wire pfcd_pkg::raw_pixel_t  pix,
  output pfcd_pkg::crc_status_t      status
);

  logic [31:0] running_crc_r;
  logic [31:0] running_crc_nxt;
  logic [31:0] prev_crc_r;
  logic [31:0] prev_crc_nxt;
  logic [31:0] crc_two;
  logic [31:0] crc_pix;
  logic [31:0] final_crc;

  always_comb begin
    crc_two   = pfcd_pkg::crc_byte(pfcd_pkg::crc_byte(running_crc_r, pix.byte_first),
                                   pix.byte_second);
    // The third byte only belongs to the frame in RGB888 mode.
    crc_pix   = (fmt == pfcd_pkg::FMT_RGB888) ? pfcd_pkg::crc_byte(crc_two, pix.byte_third)
                                              : crc_two;
    final_crc = ~crc_pix;
    status.frame_changed = pix.frame_last && (final_crc != prev_crc_r);

    running_crc_nxt = running_crc_r;
    prev_crc_nxt    = prev_crc_r;
    if (update) begin
      if (pix.frame_last) begin
        running_crc_nxt = pfcd_pkg::CRC_INIT;
        prev_crc_nxt    = final_crc;
      end else begin
        running_crc_nxt = crc_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_crc_r <= pfcd_pkg::CRC_INIT;
      prev_crc_r    <= '0;
    end else begin
      running_crc_r <= running_crc_nxt;
      prev_crc_r    <= prev_crc_nxt;
    end
  end

  a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
    update && pix.frame_last |=> running_crc_r == pfcd_pkg::CRC_INIT)
    else $error("running CRC did not restart after the last pixel");

  a_prev_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(update && pix.frame_last) |=> $stable(prev_crc_r))
    else $error("stored frame CRC changed without a frame end");

  a_crc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !update |=> $stable(running_crc_r))
    else $error("running CRC moved without an update");

endmodule

`default_nettype wire

// ===== rtl/core/pixel_expand_frame_crc_detect.sv =====
// out_tvalid rises once a pixel has passed the input register and then the result register.
// Throughput: one pixel per cycle unless out_tready stalls the output; the CRC update over
// two bytes (RGB565) or three (RGB888) and the color widening sit between the two registers.
// Reset (rst_n low, synchronous): both stages empty, running CRC all ones,
// stored previous-frame CRC zero, pixel format RGB565.
`default_nettype none

module pixel_expand_frame_crc_detect (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,    // pixel_format
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,       // byte_first, byte_second, byte_third
  input  wire logic        in_tlast,       // frame_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,      // pixel_color
  output logic             out_tlast,      // result_last
  output logic             out_tuser       // frame_changed
);

  logic                  fmt_r;
  logic                  s1_valid_r;
  pfcd_pkg::raw_pixel_t  s1_pix_r;
  logic                  out_valid_r;
  logic [23:0]           out_color_r;
  logic                  out_last_r;
  logic                  out_changed_r;
  logic                  out_adv;
  logic                  s1_fire;
  logic                  in_fire;
  logic [23:0]           color;
  pfcd_pkg::crc_status_t crc_status;

  assign out_adv   = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_adv;
  assign in_tready = !s1_valid_r || out_adv;
  assign in_fire   = in_tvalid && in_tready;

  pfcd_color u_color (
    .fmt         (fmt_r),
    .pix         (s1_pix_r),
    .pixel_color (color)
  );

  pfcd_crc u_crc (
    .clk    (clk),
    .rst_n  (rst_n),
    .update (s1_fire),
    .fmt    (fmt_r),
    .pix    (s1_pix_r),
    .status (crc_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= pfcd_pkg::FMT_RGB565;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fmt_r <= cfg_wr_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r.byte_first  <= in_tdata[7:0];
      s1_pix_r.byte_second <= in_tdata[15:8];
      s1_pix_r.byte_third  <= in_tdata[23:16];
      s1_pix_r.frame_last  <= in_tlast;
    end
    if (s1_fire) begin
      out_color_r   <= color;
      out_last_r    <= s1_pix_r.frame_last;
      out_changed_r <= crc_status.frame_changed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_color_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_changed_r;

  a_changed_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame change flagged on a pixel that is not last");

  a_stall_keeps_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_adv |=> s1_valid_r)
    else $error("input stage dropped a pixel during a stall");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input not ready with an empty input stage");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("pixel left the input stage without reaching the result stage");

endmodule

`default_nettype wire
